// ----- rtl/core/psu_pkg.sv -----
// Package: shared constants for the supply list sequencer.
package psu_pkg;

  localparam int LIST_DEPTH_DEF = 256;
  localparam int LEVEL_BITS_DEF = 16;
  localparam int DWELL_BITS_DEF = 40;

  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_TICK  = 3'd2;
  localparam logic [2:0] MODE_ABORT = 3'd3;
  localparam logic [2:0] MODE_CHECK = 3'd4;

  localparam logic [1:0] SEL_DWELL   = 2'd0;
  localparam logic [1:0] SEL_VOLTAGE = 2'd1;
  localparam logic [1:0] SEL_CURRENT = 2'd2;

  localparam logic [3:0] ST_NONE     = 4'd0;
  localparam logic [3:0] ST_OK       = 4'd1;
  localparam logic [3:0] ST_APPLIED  = 4'd2;
  localparam logic [3:0] ST_FINISHED = 4'd3;
  localparam logic [3:0] ST_VLIM     = 4'd4;
  localparam logic [3:0] ST_ILIM     = 4'd5;
  localparam logic [3:0] ST_PLIM     = 4'd6;
  localparam logic [3:0] ST_TRIP     = 4'd7;
  localparam logic [3:0] ST_EMPTY    = 4'd8;

  localparam logic [2:0] REG_VLIM  = 3'd0;
  localparam logic [2:0] REG_ILIM  = 3'd1;
  localparam logic [2:0] REG_PLIM  = 3'd2;
  localparam logic [2:0] REG_RPT   = 3'd3;
  localparam logic [2:0] REG_DLEN  = 3'd4;
  localparam logic [2:0] REG_VLEN  = 3'd5;
  localparam logic [2:0] REG_CLEN  = 3'd6;

endpackage

// ----- rtl/core/psu_modidx.sv -----
// Sequential modulo unit: reduces an index by a list length, one quotient bit a cycle.
module psu_modidx import psu_pkg::*; #(
  parameter int IW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [IW-1:0] num,
  input  logic [IW-1:0] den,
  output logic          done,
  output logic [IW-1:0] rem
);
  localparam int CW = $clog2(IW + 1);

  logic [IW:0]   acc;
  logic [IW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [IW:0]   trial;

  assign trial = {acc[IW-1:0], quo[IW-1]};

  // Restoring division, remainder only kept
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        acc  <= '0;
        quo  <= num;
        cnt  <= CW'(IW);
      end else if (busy) begin
        quo <= {quo[IW-2:0], 1'b0};
        if (trial >= {1'b0, den}) acc <= trial - {1'b0, den};
        else acc <= trial;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = acc[IW-1:0];
endmodule

// ----- rtl/core/psu_store.sv -----
// List memories: dwell, voltage and current stores with registered reads.
module psu_store import psu_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int DWELL_BITS = DWELL_BITS_DEF,
  parameter int AW = $clog2(LIST_DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [1:0]            wsel,
  input  logic [AW-1:0]         waddr,
  input  logic [DWELL_BITS-1:0] wdata,
  input  logic [AW-1:0]         raddr_d,
  input  logic [AW-1:0]         raddr_v,
  input  logic [AW-1:0]         raddr_c,
  output logic [DWELL_BITS-1:0] rdata_d,
  output logic [LEVEL_BITS-1:0] rdata_v,
  output logic [LEVEL_BITS-1:0] rdata_c
);
  logic [DWELL_BITS-1:0] dmem [LIST_DEPTH];
  logic [LEVEL_BITS-1:0] vmem [LIST_DEPTH];
  logic [LEVEL_BITS-1:0] cmem [LIST_DEPTH];

  // Write one list, read all three
  always_ff @(posedge clk) begin
    if (we && wsel == SEL_DWELL) dmem[waddr] <= wdata;
    if (we && wsel == SEL_VOLTAGE) vmem[waddr] <= wdata[LEVEL_BITS-1:0];
    if (we && wsel == SEL_CURRENT) cmem[waddr] <= wdata[LEVEL_BITS-1:0];
    rdata_d <= dmem[raddr_d];
    rdata_v <= vmem[raddr_v];
    rdata_c <= cmem[raddr_c];
  end
endmodule

// ----- rtl/core/psu_list_sequencer_unit.sv -----
// Top level: supply list sequencer with run control, limit checks and check walk.
//
// Usage: drive mode and the item fields with start high while busy is low;
// the item is transferred at that edge. Exactly one result per item appears
// later on the result ports with done high for one cycle; the receiver
// cannot stall, so results are never held back.
// Configuration: cfg_we, cfg_index, cfg_data write a register; the user must
// write only while the block is idle, which the block itself does not enforce.
// Flow: load, abort and unknown modes, and a tick without a point change,
// go straight to the result; a point change (start or dwell expiry) runs
// three modulo reductions, then a memory read, a limit multiply and a
// compare. Check walks the longer of the voltage and current lists, with two
// modulo reductions and a memory read per entry, through the sequential
// modulo unit and the memory read port.
// Reset clears the run state and restores register defaults; the list
// memories are not cleared and must be loaded before use.
module psu_list_sequencer_unit import psu_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int DWELL_BITS = DWELL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [2:0]            mode,
  input  logic [1:0]            list_select,
  input  logic [7:0]            entry_index,
  input  logic [39:0]           entry_value,
  input  logic [15:0]           elapsed_us,
  input  logic                  inhibited,
  input  logic                  tripped,
  output logic                  done,
  output logic [3:0]            status,
  output logic                  running,
  output logic [7:0]            point_index,
  output logic [15:0]           set_voltage,
  output logic [15:0]           set_current,
  output logic                  voltage_changed,
  output logic                  current_changed,
  output logic [39:0]           remaining_dwell
);
  localparam int AW = $clog2(LIST_DEPTH);
  localparam int LW = AW + 1;
  localparam int IW = (LW > 9) ? LW : 9;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_ADV   = 4'd2;
  localparam logic [3:0] S_MODV  = 4'd3;
  localparam logic [3:0] S_MODC  = 4'd4;
  localparam logic [3:0] S_MODD  = 4'd5;
  localparam logic [3:0] S_READ  = 4'd6;
  localparam logic [3:0] S_DATA  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_CMP   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // configuration
  logic [15:0] vlim, ilim, rpt;
  logic [31:0] plim;
  logic [8:0]  dlen_r, vlen_r, clen_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vlim <= 16'hFFFF; ilim <= 16'hFFFF; plim <= 32'hFFFF_FFFF; rpt <= 16'd1;
      dlen_r <= '0; vlen_r <= '0; clen_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VLIM: vlim   <= cfg_data[15:0];
        REG_ILIM: ilim   <= cfg_data[15:0];
        REG_PLIM: plim   <= cfg_data;
        REG_RPT:  rpt    <= cfg_data[15:0];
        REG_DLEN: dlen_r <= cfg_data[8:0];
        REG_VLEN: vlen_r <= cfg_data[8:0];
        REG_CLEN: clen_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // effective lengths, saturated to the depth
  function automatic logic [LW-1:0] eff(input logic [8:0] r);
    logic [IW-1:0] x;
    x = IW'(r);
    return (x > IW'(LIST_DEPTH)) ? LW'(LIST_DEPTH) : LW'(x);
  endfunction

  logic [LW-1:0] dl, vl, cl, mx, mxvc;
  always_comb begin
    dl = eff(dlen_r); vl = eff(vlen_r); cl = eff(clen_r);
    mxvc = (vl > cl) ? vl : cl;
    mx = (dl > mxvc) ? dl : mxvc;
  end

  // captured item
  logic [2:0]            md;
  logic [1:0]            sel;
  logic [7:0]            eidx;
  logic [DWELL_BITS-1:0] evalue;
  logic [15:0]           elap;
  logic                  inh, trp;

  // run state
  logic                  run_flag, first_pend;
  logic [7:0]            step;
  logic [15:0]           reps;
  logic [DWELL_BITS:0]   dwell_left;
  logic [LEVEL_BITS-1:0] last_v, last_c;

  logic [3:0]            state;
  logic                  checking;
  logic [LW-1:0]         nxt;
  logic [LEVEL_BITS-1:0] v_r, c_r;
  logic [2*LEVEL_BITS-1:0] prod;
  logic [AW-1:0]         ai_d, ai_v, ai_c;

  // modulo unit, shared for the three lists
  logic          mgo, mdone;
  logic [IW-1:0] mnum, mden, mrem;
  psu_modidx #(.IW(IW)) u_mod (
    .clk(clk), .rst(rst), .go(mgo), .num(mnum), .den(mden),
    .done(mdone), .rem(mrem)
  );

  // memories
  logic                  mwe;
  logic [DWELL_BITS-1:0] rd_d;
  logic [LEVEL_BITS-1:0] rd_v, rd_c;
  psu_store #(
    .LIST_DEPTH(LIST_DEPTH), .LEVEL_BITS(LEVEL_BITS), .DWELL_BITS(DWELL_BITS)
  ) u_store (
    .clk(clk), .we(mwe), .wsel(sel), .waddr(AW'(eidx)), .wdata(evalue),
    .raddr_d(ai_d), .raddr_v(ai_v), .raddr_c(ai_c),
    .rdata_d(rd_d), .rdata_v(rd_v), .rdata_c(rd_c)
  );

  assign mwe = (state == S_DISP) && (md == MODE_LOAD) && (sel <= SEL_CURRENT)
               && ({1'b0, eidx} < 9'(LIST_DEPTH > 256 ? 256 : LIST_DEPTH));
  assign busy = (state != S_IDLE);

  logic [3:0] st;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; done <= 1'b0; mgo <= 1'b0;
      run_flag <= 1'b0; first_pend <= 1'b1; step <= '0; reps <= '0;
      dwell_left <= '0; last_v <= '0; last_c <= '0;
      status <= ST_NONE; voltage_changed <= 1'b0; current_changed <= 1'b0;
      checking <= 1'b0;
    end else begin
      done <= 1'b0;
      mgo  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            md <= mode; sel <= list_select; eidx <= entry_index;
            evalue <= DWELL_BITS'(entry_value); elap <= elapsed_us;
            inh <= inhibited; trp <= tripped;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          st <= ST_NONE;
          voltage_changed <= 1'b0; current_changed <= 1'b0;
          checking <= 1'b0;
          state <= S_OUT;
          case (md)
            MODE_LOAD: if (mwe) st <= ST_OK;
            MODE_ABORT: begin
              run_flag <= 1'b0; st <= ST_OK;
            end
            MODE_CHECK: begin
              if (vl == '0 || cl == '0) st <= ST_EMPTY;
              else begin
                checking <= 1'b1; nxt <= '0; st <= ST_OK;
                mnum <= '0; mden <= IW'(vl); mgo <= 1'b1; state <= S_MODV;
              end
            end
            MODE_START, MODE_TICK: begin
              if (md == MODE_START) begin
                first_pend <= 1'b1; reps <= rpt;
              end
              if (md == MODE_TICK && !run_flag) st <= ST_NONE;
              else if (trp) begin
                run_flag <= 1'b0; st <= ST_TRIP;
              end else if (inh) begin
                if (md == MODE_START) run_flag <= 1'b1;
                st <= ST_OK;
              end else if (md == MODE_START || first_pend ||
                           dwell_left <= (DWELL_BITS+1)'(elap)) begin
                run_flag <= 1'b1;
                state <= S_ADV;
              end else begin
                dwell_left <= dwell_left - (DWELL_BITS+1)'(elap);
                st <= ST_OK;
              end
            end
            default: ;
          endcase
        end
        S_ADV: begin
          state <= S_OUT;
          if (dl == '0 || vl == '0 || cl == '0) begin
            run_flag <= 1'b0; st <= ST_EMPTY;
          end else begin
            first_pend <= 1'b0;
            if ((first_pend ? {LW{1'b0}} : LW'(step) + 1'b1) >= mx) begin
              nxt <= '0;
              if (reps != '0) begin
                reps <= reps - 1'b1;
                if (reps == 16'd1) begin
                  run_flag <= 1'b0; st <= ST_FINISHED;
                end else begin
                  mnum <= '0; mden <= IW'(vl); mgo <= 1'b1; state <= S_MODV;
                end
              end else begin
                mnum <= '0; mden <= IW'(vl); mgo <= 1'b1; state <= S_MODV;
              end
            end else begin
              nxt  <= first_pend ? {LW{1'b0}} : LW'(step) + 1'b1;
              mnum <= IW'(first_pend ? {LW{1'b0}} : LW'(step) + 1'b1);
              mden <= IW'(vl); mgo <= 1'b1; state <= S_MODV;
            end
          end
        end
        S_MODV: if (mdone) begin
          ai_v <= AW'(mrem);
          mnum <= IW'(nxt); mden <= IW'(cl); mgo <= 1'b1; state <= S_MODC;
        end
        S_MODC: if (mdone) begin
          ai_c <= AW'(mrem);
          if (checking) state <= S_READ;
          else begin
            mnum <= IW'(nxt); mden <= IW'(dl); mgo <= 1'b1; state <= S_MODD;
          end
        end
        S_MODD: if (mdone) begin
          ai_d <= AW'(mrem); state <= S_READ;
        end
        S_READ: state <= S_DATA;
        S_DATA: begin
          v_r <= rd_v; c_r <= rd_c; state <= S_MUL;
        end
        S_MUL: begin
          prod <= v_r * c_r; state <= S_CMP;
        end
        S_CMP: begin
          // limit compare, then apply the point, stop the run, or continue the walk
          logic [3:0] ls;
          ls = ST_OK;
          if (32'(v_r) > 32'(vlim)) ls = ST_VLIM;
          else if (32'(c_r) > 32'(ilim)) ls = ST_ILIM;
          else if (64'(prod) > 64'(plim)) ls = ST_PLIM;
          state <= S_OUT;
          if (checking) begin
            st <= ls;
            if (ls == ST_OK && nxt + 1'b1 < mxvc) begin
              nxt <= nxt + 1'b1;
              mnum <= IW'(nxt + 1'b1); mden <= IW'(vl); mgo <= 1'b1;
              state <= S_MODV;
            end
          end else if (ls != ST_OK) begin
            run_flag <= 1'b0; st <= ls;
          end else begin
            step <= 8'(nxt);
            voltage_changed <= (v_r != last_v);
            current_changed <= (c_r != last_c);
            last_v <= v_r; last_c <= c_r;
            dwell_left <= (DWELL_BITS+1)'(rd_d);
            st <= ST_APPLIED;
          end
        end
        S_OUT: begin
          status <= st;
          if (st != ST_APPLIED) begin
            voltage_changed <= 1'b0; current_changed <= 1'b0;
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign running = run_flag;
  assign point_index = step;
  assign set_voltage = 16'(last_v);
  assign set_current = 16'(last_c);
  assign remaining_dwell = run_flag ? 40'(dwell_left) : 40'd0;
endmodule
